[rtl/core/cra_pkg.sv]
package cra_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // field widths
    localparam int CODE_W  = 2;
    localparam int LAG_W   = 10;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 21;
    localparam int ORIG_W  = 11;
    localparam int RATIO_W = 27;
    localparam int FRAC_W  = 16;

    // stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 16;
    localparam int IN_PAD_W    = IN_TDATA_W - CODE_W - LAG_W;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - COUNT_W - ORIG_W - RATIO_W - 1;

    // saturation limits
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(1048576);
    localparam logic [RATIO_W-1:0] RATIO_CAP = RATIO_W'(67108864);

    // register reset and default sizes
    localparam logic [CODE_W-1:0] TARGET_RESET = 2'd1;
    localparam int DEFAULT_MAX_MOLS   = 1024;
    localparam int DEFAULT_MAX_FRAMES = 1024;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_HIST,
        ST_SUM,
        ST_SUM_END,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

[rtl/core/cra_ram.sv]
module cra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/continuous_residence_acf_top.sv]
// a sample whose code matches the target goes on to ST_RUN (run read) and ST_HIST (histogram update)
// a read walks the histogram from lag to MAX_FRAMES - 1, one entry per cycle,
// then runs the bit-serial divider when origins exist, then loads the output register
// throughput: one item at a time; s_axis_tready is low while an item is worked on
// reset and clear items run a clearing pass over both memories, up to max(MAX_MOLS, MAX_FRAMES) entries
// rst_n is asynchronous and active low; target_code resets to 1
module continuous_residence_acf_top #(
    parameter int MAX_MOLS   = cra_pkg::DEFAULT_MAX_MOLS,
    parameter int MAX_FRAMES = cra_pkg::DEFAULT_MAX_FRAMES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [cra_pkg::CODE_W-1:0]           cfg_wdata,    // target_code
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [cra_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // code[1:0], lag[11:2]
    input  logic                                 s_axis_tlast,  // frame_end
    input  logic [cra_pkg::KIND_W-1:0]           s_axis_tuser,  // kind
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pair_count[20:0], origin_count[31:21], ratio[58:32], overflow[59]
    output logic [cra_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    // derived widths
    localparam int AW_M    = (MAX_MOLS > 1) ? $clog2(MAX_MOLS) : 1;
    localparam int MEM_M   = (MAX_MOLS > 1) ? MAX_MOLS : 2;
    localparam int AW_F    = $clog2(MAX_FRAMES);
    localparam int SW      = $clog2(MAX_MOLS + 1);
    localparam int FW      = $clog2(MAX_FRAMES + 1);
    localparam int RW      = FW;
    localparam int CLR_N   = (MAX_MOLS > MAX_FRAMES) ? MAX_MOLS : MAX_FRAMES;
    localparam int CW      = $clog2(CLR_N);
    localparam int CMPW    = (FW > cra_pkg::LAG_W) ? FW : cra_pkg::LAG_W;
    localparam int QW      = cra_pkg::COUNT_W + cra_pkg::FRAC_W;
    localparam int STW     = $clog2(QW);
    localparam int CW_N    = cra_pkg::COUNT_W;

    // registers
    cra_pkg::state_t          state_reg, state_next;
    logic [cra_pkg::CODE_W-1:0] target_reg;
    logic [FW-1:0]            frames_reg, frames_next;
    logic [SW-1:0]            slot_reg, slot_next;
    logic                     ovf_reg, ovf_next;
    logic [CW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic                     rvld_reg, rvld_next;
    logic                     sat_reg, sat_next;
    logic                     out_valid_reg, out_valid_next;
    logic [STW-1:0]           step_reg, step_next;
    logic [AW_M-1:0]          run_addr_reg, run_addr_next;
    logic [AW_F-1:0]          hist_addr_reg, hist_addr_next;
    logic [AW_F-1:0]          sum_addr_reg, sum_addr_next;
    logic [CW_N-1:0]          acc_reg, acc_next;
    logic [FW-1:0]            div_reg, div_next;
    logic [FW-1:0]            rem_reg, rem_next;
    logic [QW-1:0]            quo_reg, quo_next;
    logic [cra_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // memory ports
    logic            run_we, run_re;
    logic [AW_M-1:0] run_waddr, run_raddr;
    logic [RW-1:0]   run_wdata, run_rdata;
    logic            hist_we, hist_re;
    logic [AW_F-1:0] hist_waddr, hist_raddr;
    logic [CW_N-1:0] hist_wdata, hist_rdata;

    // input fields
    logic                       in_xfer;
    logic [cra_pkg::CODE_W-1:0] in_code;
    logic [cra_pkg::LAG_W-1:0]  in_lag;

    // datapath helpers
    logic [CMPW-1:0]   lag_ext, frames_ext, orig_ext;
    logic [RW:0]       r_inc;
    logic [RW-1:0]     r_val;
    logic [CW_N:0]     acc_sum;
    logic [CW_N-1:0]   acc_add;
    logic              sat_add;
    logic [FW:0]       rem_shift, rem_diff;
    logic              rem_ge;
    logic [cra_pkg::RATIO_W-1:0] ratio_val;

    assign in_code       = s_axis_tdata[cra_pkg::CODE_W-1:0];
    assign in_lag        = s_axis_tdata[cra_pkg::CODE_W +: cra_pkg::LAG_W];
    assign s_axis_tready = (state_reg == cra_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // run length store, one entry per molecule slot
    cra_ram #(
        .WIDTH (RW),
        .DEPTH (MEM_M)
    ) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (run_waddr),
        .wdata (run_wdata),
        .re    (run_re),
        .raddr (run_raddr),
        .rdata (run_rdata)
    );

    // reach histogram, entry k counts reaches of run length k+1
    cra_ram #(
        .WIDTH (CW_N),
        .DEPTH (MAX_FRAMES)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // origin count for a read: frames seen minus lag, floored at zero
    assign lag_ext    = CMPW'(in_lag);
    assign frames_ext = CMPW'(frames_reg);
    assign orig_ext   = (lag_ext < frames_ext) ? (frames_ext - lag_ext) : '0;

    // run length step, capped at the frame capacity
    assign r_inc = {1'b0, run_rdata} + (RW+1)'(1);
    assign r_val = (r_inc > (RW+1)'(MAX_FRAMES)) ? RW'(MAX_FRAMES) : r_inc[RW-1:0];

    // saturating suffix sum adder
    assign acc_sum = {1'b0, acc_reg} + {1'b0, hist_rdata};
    assign sat_add = (acc_sum > {1'b0, cra_pkg::COUNT_CAP});
    assign acc_add = sat_add ? cra_pkg::COUNT_CAP : acc_sum[CW_N-1:0];

    // restoring divider step, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[QW-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    // ratio clamp
    assign ratio_val = (quo_reg > QW'(cra_pkg::RATIO_CAP)) ? cra_pkg::RATIO_CAP
                                                           : quo_reg[cra_pkg::RATIO_W-1:0];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cra_pkg::ST_CLEAR;
            target_reg    <= cra_pkg::TARGET_RESET;
            frames_reg    <= '0;
            slot_reg      <= '0;
            ovf_reg       <= 1'b0;
            clr_cnt_reg   <= '0;
            rvld_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            frames_reg    <= frames_next;
            slot_reg      <= slot_next;
            ovf_reg       <= ovf_next;
            clr_cnt_reg   <= clr_cnt_next;
            rvld_reg      <= rvld_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        run_addr_reg  <= run_addr_next;
        hist_addr_reg <= hist_addr_next;
        sum_addr_reg  <= sum_addr_next;
        acc_reg       <= acc_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        out_data_reg  <= out_data_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        frames_next    = frames_reg;
        slot_next      = slot_reg;
        ovf_next       = ovf_reg;
        clr_cnt_next   = clr_cnt_reg;
        rvld_next      = 1'b0;
        sat_next       = sat_reg;
        step_next      = step_reg;
        run_addr_next  = run_addr_reg;
        hist_addr_next = hist_addr_reg;
        sum_addr_next  = sum_addr_reg;
        acc_next       = acc_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        run_we     = 1'b0;
        run_waddr  = run_addr_reg;
        run_wdata  = '0;
        run_re     = 1'b0;
        run_raddr  = slot_reg[AW_M-1:0];
        hist_we    = 1'b0;
        hist_waddr = hist_addr_reg;
        hist_wdata = '0;
        hist_re    = 1'b0;
        hist_raddr = sum_addr_reg;

        unique case (state_reg)
            // sweep both memories back to zero
            cra_pkg::ST_CLEAR:
            begin
                run_waddr  = clr_cnt_reg[AW_M-1:0];
                hist_waddr = clr_cnt_reg[AW_F-1:0];
                run_we     = (int'(clr_cnt_reg) < MAX_MOLS);
                hist_we    = (int'(clr_cnt_reg) < MAX_FRAMES);
                if (clr_cnt_reg == CW'(CLR_N - 1))
                begin
                    state_next = cra_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CW'(1);
                end
            end

            // take an item
            cra_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (s_axis_tuser)
                        cra_pkg::KIND_SAMPLE:
                        begin
                            if (frames_reg >= FW'(MAX_FRAMES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                if (slot_reg < SW'(MAX_MOLS))
                                begin
                                    run_addr_next = slot_reg[AW_M-1:0];
                                    if (in_code == target_reg)
                                    begin
                                        run_re     = 1'b1;
                                        state_next = cra_pkg::ST_RUN;
                                    end
                                    else
                                    begin
                                        run_we    = 1'b1;
                                        run_waddr = slot_reg[AW_M-1:0];
                                    end
                                    slot_next = slot_reg + SW'(1);
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                                if (s_axis_tlast)
                                begin
                                    frames_next = frames_reg + FW'(1);
                                    slot_next   = '0;
                                end
                            end
                        end
                        cra_pkg::KIND_READ:
                        begin
                            acc_next = '0;
                            sat_next = 1'b0;
                            if (int'(in_lag) >= MAX_FRAMES)
                            begin
                                ovf_next   = 1'b1;
                                div_next   = '0;
                                quo_next   = '0;
                                state_next = cra_pkg::ST_OUT;
                            end
                            else
                            begin
                                sum_addr_next = AW_F'(in_lag);
                                div_next      = FW'(orig_ext);
                                state_next    = cra_pkg::ST_SUM;
                            end
                        end
                        cra_pkg::KIND_CLEAR:
                        begin
                            frames_next  = '0;
                            slot_next    = '0;
                            ovf_next     = 1'b0;
                            clr_cnt_next = '0;
                            state_next   = cra_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = cra_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // extend the run and fetch its histogram entry
            cra_pkg::ST_RUN:
            begin
                run_we         = 1'b1;
                run_wdata      = r_val;
                hist_re        = 1'b1;
                hist_raddr     = AW_F'(r_val - RW'(1));
                hist_addr_next = AW_F'(r_val - RW'(1));
                state_next     = cra_pkg::ST_HIST;
            end

            // count one more reach, saturating
            cra_pkg::ST_HIST:
            begin
                if (hist_rdata >= cra_pkg::COUNT_CAP)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    hist_we    = 1'b1;
                    hist_wdata = hist_rdata + CW_N'(1);
                end
                state_next = cra_pkg::ST_IDLE;
            end

            // walk the histogram from lag to the top
            cra_pkg::ST_SUM:
            begin
                hist_re   = 1'b1;
                rvld_next = 1'b1;
                if (rvld_reg)
                begin
                    acc_next = acc_add;
                    sat_next = sat_reg | sat_add;
                end
                if (sum_addr_reg == AW_F'(MAX_FRAMES - 1))
                begin
                    state_next = cra_pkg::ST_SUM_END;
                end
                else
                begin
                    sum_addr_next = sum_addr_reg + AW_F'(1);
                end
            end

            // last entry in, start the divider
            cra_pkg::ST_SUM_END:
            begin
                acc_next = acc_add;
                sat_next = sat_reg | sat_add;
                rem_next = '0;
                if (div_reg == '0)
                begin
                    quo_next   = '0;
                    state_next = cra_pkg::ST_OUT;
                end
                else
                begin
                    quo_next   = {acc_add, {cra_pkg::FRAC_W{1'b0}}};
                    step_next  = STW'(QW - 1);
                    state_next = cra_pkg::ST_DIV;
                end
            end

            // one quotient bit per cycle
            cra_pkg::ST_DIV:
            begin
                rem_next = rem_ge ? rem_diff[FW-1:0] : rem_shift[FW-1:0];
                quo_next = {quo_reg[QW-2:0], rem_ge};
                if (step_reg == '0)
                begin
                    state_next = cra_pkg::ST_OUT;
                end
                else
                begin
                    step_next = step_reg - STW'(1);
                end
            end

            // hand the result to the output register once it is free
            cra_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    ovf_next       = ovf_reg | sat_reg;
                    out_data_next  = {{cra_pkg::OUT_PAD_W{1'b0}},
                                      ovf_reg | sat_reg,
                                      ratio_val,
                                      cra_pkg::ORIG_W'(div_reg),
                                      acc_reg};
                    state_next     = cra_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cra_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/cra_checker.sv]
module cra_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [cra_pkg::KIND_W-1:0]        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [cra_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int ORIG_LO  = cra_pkg::COUNT_W;
    localparam int RATIO_LO = cra_pkg::COUNT_W + cra_pkg::ORIG_W;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // pair count never exceeds its cap
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[cra_pkg::COUNT_W-1:0] <= cra_pkg::COUNT_CAP)
        else $error("pair count above cap");

    // ratio never exceeds its cap
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[RATIO_LO +: cra_pkg::RATIO_W] <= cra_pkg::RATIO_CAP)
        else $error("ratio above cap");

    // no origins means zero ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[ORIG_LO +: cra_pkg::ORIG_W] == '0)
        |-> m_axis_tdata[RATIO_LO +: cra_pkg::RATIO_W] == '0)
        else $error("ratio nonzero without origins");

    // a clear item starts the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == cra_pkg::KIND_CLEAR)
        |=> !s_axis_tready)
        else $error("ready during clearing pass");

endmodule

bind continuous_residence_acf_top cra_checker u_cra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/continuous_residence_acf_top_test.sv]
module continuous_residence_acf_top_test;

    localparam int N_MOLS        = cra_pkg::DEFAULT_MAX_MOLS;
    localparam int N_FRAMES      = cra_pkg::DEFAULT_MAX_FRAMES;
    localparam logic [cra_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int IDLE_PCT      = 8;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = N_FRAMES + 64;
    localparam int READOUT_W     = cra_pkg::COUNT_W + cra_pkg::ORIG_W + cra_pkg::RATIO_W + 1;
    localparam int PHASES        = 2;
    localparam int READ_EVERY    = 128;

    typedef struct packed {
        logic [cra_pkg::KIND_W-1:0] kind;
        logic [cra_pkg::CODE_W-1:0] code;
        logic                       frame_end;
        logic [cra_pkg::LAG_W-1:0]  lag;
    } acf_item_t;

    // same bit order as the output tdata, pair count in the low bits
    typedef struct packed {
        logic                        overflow;
        logic [cra_pkg::RATIO_W-1:0] ratio;
        logic [cra_pkg::ORIG_W-1:0]  origins;
        logic [cra_pkg::COUNT_W-1:0] pairs;
    } readout_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [cra_pkg::CODE_W-1:0]      cfg_wdata = cra_pkg::TARGET_RESET;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [cra_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;    // code[1:0], lag[11:2]
    logic                            s_axis_tlast = 1'b0;  // frame_end
    logic [cra_pkg::KIND_W-1:0]      s_axis_tuser = cra_pkg::KIND_SAMPLE;  // kind
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // pair_count[20:0], origin_count[31:21], ratio[58:32], overflow[59]
    logic [cra_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    continuous_residence_acf_top #(
        .MAX_MOLS   (N_MOLS),
        .MAX_FRAMES (N_FRAMES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted block state
    int unsigned                run_len [N_MOLS];
    int unsigned                reach_cnt [N_FRAMES];
    int unsigned                frames_done;
    int unsigned                mol_slot;
    bit                         ovf_sticky;
    logic [cra_pkg::CODE_W-1:0] target_sel = cra_pkg::TARGET_RESET;

    acf_item_t pending_items[$];
    readout_t  pending_readouts[$];
    acf_item_t drive_item;

    int     frames_gen;
    int     items_sent;
    int     readouts_checked;
    int     settings_written;
    int     errors;
    int     hold_left;
    bit     hold_used;
    bit     steady_run;
    longint est_cycles = 20000;
    longint cycle_count;

    function automatic void clear_residence();
        foreach (run_len[i])
            run_len[i] = 0;
        foreach (reach_cnt[i])
            reach_cnt[i] = 0;
        frames_done = 0;
        mol_slot = 0;
        ovf_sticky = 1'b0;
    endfunction

    // advance the predicted state by one item, queue the readout it causes
    function automatic void residence_step(input acf_item_t it);
        int unsigned     r;
        longint unsigned sum;
        longint unsigned orig;
        longint unsigned quo;
        readout_t        res;
        case (it.kind)
            cra_pkg::KIND_SAMPLE:
            begin
                if (frames_done >= N_FRAMES)
                begin
                    // frame budget used up, frame_end ignored too
                    ovf_sticky = 1'b1;
                end
                else
                begin
                    if (mol_slot < N_MOLS)
                    begin
                        if (it.code == target_sel)
                        begin
                            r = run_len[mol_slot] + 1;
                            if (r > N_FRAMES)
                                r = N_FRAMES;
                            run_len[mol_slot] = r;
                            if (reach_cnt[r-1] >= cra_pkg::COUNT_CAP)
                                ovf_sticky = 1'b1;
                            else
                                reach_cnt[r-1]++;
                        end
                        else
                        begin
                            run_len[mol_slot] = 0;
                        end
                        mol_slot++;
                    end
                    else
                    begin
                        ovf_sticky = 1'b1;
                    end
                    if (it.frame_end)
                    begin
                        frames_done++;
                        mol_slot = 0;
                    end
                end
            end
            cra_pkg::KIND_READ:
            begin
                sum = 0;
                orig = 0;
                quo = 0;
                if (it.lag >= N_FRAMES)
                begin
                    ovf_sticky = 1'b1;
                end
                else
                begin
                    // suffix sum of reach counts beyond the lag
                    for (int k = it.lag; k < N_FRAMES; k++)
                        sum += reach_cnt[k];
                    if (sum > cra_pkg::COUNT_CAP)
                    begin
                        sum = cra_pkg::COUNT_CAP;
                        ovf_sticky = 1'b1;
                    end
                    if (it.lag < frames_done)
                        orig = frames_done - it.lag;
                    if (orig != 0)
                    begin
                        quo = (sum << cra_pkg::FRAC_W) / orig;
                        if (quo > cra_pkg::RATIO_CAP)
                            quo = cra_pkg::RATIO_CAP;
                    end
                end
                res.pairs = sum[cra_pkg::COUNT_W-1:0];
                res.origins = orig[cra_pkg::ORIG_W-1:0];
                res.ratio = quo[cra_pkg::RATIO_W-1:0];
                res.overflow = ovf_sticky;
                pending_readouts = {pending_readouts, res};
            end
            cra_pkg::KIND_CLEAR:
                clear_residence();
            default:
                ;
        endcase
    endfunction

    // stimulus queueing, with a rough cycle cost for the run limit
    function automatic void queue_item(input logic [cra_pkg::KIND_W-1:0] kind,
                                       input logic [cra_pkg::CODE_W-1:0] code,
                                       input logic last,
                                       input logic [cra_pkg::LAG_W-1:0] lag);
        acf_item_t it;
        it.kind = kind;
        it.code = code;
        it.frame_end = last;
        it.lag = lag;
        pending_items = {pending_items, it};
        case (kind)
            cra_pkg::KIND_READ:  est_cycles += N_FRAMES - lag + 48;
            cra_pkg::KIND_CLEAR: est_cycles += N_FRAMES + N_MOLS + 16;
            default:             est_cycles += 4;
        endcase
        if (kind == cra_pkg::KIND_SAMPLE && last)
            frames_gen++;
        if (kind == cra_pkg::KIND_CLEAR)
            frames_gen = 0;
    endfunction

    function automatic void queue_sample(input logic [cra_pkg::CODE_W-1:0] code,
                                         input logic last);
        queue_item(cra_pkg::KIND_SAMPLE, code, last,
                   cra_pkg::LAG_W'($urandom_range(0, N_FRAMES - 1)));
    endfunction

    function automatic void queue_read(input logic [cra_pkg::LAG_W-1:0] lag);
        queue_item(cra_pkg::KIND_READ, cra_pkg::CODE_W'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), lag);
    endfunction

    function automatic void queue_clear();
        queue_item(cra_pkg::KIND_CLEAR, cra_pkg::CODE_W'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), cra_pkg::LAG_W'($urandom_range(0, N_FRAMES - 1)));
    endfunction

    // mostly the target code so that runs grow
    function automatic logic [cra_pkg::CODE_W-1:0] pick_code(input int target_pct);
        if ($urandom_range(0, 99) < target_pct)
            return target_sel;
        return cra_pkg::CODE_W'($urandom_range(0, 3));
    endfunction

    // lags around the frames seen so far, origins mostly present
    function automatic logic [cra_pkg::LAG_W-1:0] pick_lag();
        if (frames_gen >= N_FRAMES - 1)
            return cra_pkg::LAG_W'($urandom_range(0, N_FRAMES - 1));
        return cra_pkg::LAG_W'($urandom_range(0, frames_gen + 1));
    endfunction

    // first mismatches in full, the rest only counted
    function automatic void report_mismatch(input readout_t want, input readout_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("readout %0d: expected pairs %0d origins %0d ratio %0d ovf %0d",
                     readouts_checked, want.pairs, want.origins, want.ratio, want.overflow);
            $display("    got pairs %0d origins %0d ratio %0d ovf %0d",
                     got.pairs, got.origins, got.ratio, got.overflow);
        end
    endfunction

    task automatic write_target(input logic [cra_pkg::CODE_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        target_sel = value;
        settings_written++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait for the stream to drain, then for a trailing sample or clear to finish
    task automatic settle();
        @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || pending_readouts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        est_cycles += SETTLE_CYCLES;
    endtask

    // input driver: one transfer per handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                residence_step(drive_item);
                items_sent <= items_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 &&
                    (steady_run || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    drive_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{cra_pkg::IN_PAD_W{1'b0}}, drive_item.lag, drive_item.code};
                    s_axis_tlast <= drive_item.frame_end;
                    s_axis_tuser <= drive_item.kind;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off once, while items are still queued
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_used && readouts_checked >= 5 && pending_items.size() > 10)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // output monitor and checker
    always @(posedge clk)
    begin
        readout_t got;
        readout_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = readout_t'(m_axis_tdata[READOUT_W-1:0]);
                readouts_checked <= readouts_checked + 1;
                if (pending_readouts.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected readout: pairs %0d origins %0d ratio %0d ovf %0d",
                                 got.pairs, got.origins, got.ratio, got.overflow);
                end
                else
                begin
                    want = pending_readouts.pop_front();
                    if (got.pairs !== want.pairs || got.origins !== want.origins ||
                        got.ratio !== want.ratio || got.overflow !== want.overflow)
                        report_mismatch(want, got);
                end
            end
            m_axis_tready <= (hold_left == 0) &&
                             (steady_run || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4 * est_cycles + HOLD_CYCLES)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        int nmol;
        int nfr;
        int len;
        int roll;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // memories are cleared after reset
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        write_target(cra_pkg::TARGET_RESET);

        // directed: empty read, matching and broken runs, short frame, spare kind, top lag, clear
        queue_read(10'd0);
        queue_sample(2'd1, 1'b0);
        queue_sample(2'd0, 1'b0);
        queue_sample(2'd1, 1'b1);
        queue_sample(2'd1, 1'b0);
        queue_sample(2'd3, 1'b1);
        queue_sample(2'd1, 1'b1);
        queue_item(KIND_SPARE, 2'd3, 1'b1, 10'd1023);
        queue_read(10'd0);
        queue_read(10'd1);
        queue_read(10'd2);
        queue_read(10'd3);
        queue_read(10'd1023);
        queue_item(cra_pkg::KIND_SAMPLE, 2'd2, 1'b0, 10'd1023);
        queue_clear();
        queue_read(10'd0);
        settle();

        // random phases of well-formed frames with some noise
        for (int p = 0; p < PHASES; p++)
        begin
            steady_run = 1'b0;
            if (p == 0)
                write_target(2'd0);
            else if (p == 1)
                write_target(2'd3);
            else
                write_target(cra_pkg::CODE_W'($urandom_range(0, 3)));
            if (p % 3 == 0)
                queue_clear();
            nmol = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            nfr = $urandom_range(2, 2 + 40 / nmol);
            for (int f = 0; f < nfr; f++)
            begin
                len = nmol;
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    len = $urandom_range(1, nmol);
                else if (roll < 15)
                    len = nmol + 1;
                for (int s = 0; s < len; s++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        queue_item(KIND_SPARE, cra_pkg::CODE_W'($urandom_range(0, 3)),
                                   1'($urandom_range(0, 1)),
                                   cra_pkg::LAG_W'($urandom_range(0, 1023)));
                    else if (roll < 5)
                        queue_read(cra_pkg::LAG_W'($urandom_range(0, N_FRAMES - 1)));
                    else if (roll == 5)
                        queue_clear();
                    queue_sample(pick_code(70), s == len - 1);
                end
                if ($urandom_range(0, 99) < 15)
                    queue_read(pick_lag());
            end
            queue_read(pick_lag());
            queue_read(pick_lag());
            queue_read(pick_lag());
            queue_read(cra_pkg::LAG_W'($urandom_range(0, N_FRAMES - 1)));
            settle();
        end

        // single-molecule frames past the frame limit, reads along the way, no idling
        steady_run = 1'b1;
        write_target(cra_pkg::CODE_W'($urandom_range(0, 3)));
        queue_clear();
        for (int f = 0; f < N_FRAMES + 6; f++)
        begin
            queue_sample(pick_code(90), 1'b1);
            if (f % READ_EVERY == READ_EVERY - 1)
                queue_read(pick_lag());
        end
        for (int s = 0; s < 4; s++)
            queue_sample(pick_code(50), 1'($urandom_range(0, 1)));
        queue_read(10'd0);
        queue_read(10'd1);
        queue_read(10'd1022);
        queue_read(10'd1023);
        queue_read(cra_pkg::LAG_W'($urandom_range(0, N_FRAMES - 1)));
        settle();
        steady_run = 1'b0;

        errors += pending_readouts.size();
        $display("%0d transfers in, %0d readouts checked, %0d target settings, %0d cycles",
                 items_sent, readouts_checked, settings_written, cycle_count);
        $display("covered short frames, spare kinds, clears, the frame limit and a %0d-cycle %s",
                 HOLD_CYCLES, "output stall");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
